FILE: hw/rtl/qte_pkg.sv
`default_nettype none
package qte_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int ATAN_LEN = 24;
  localparam int PW = 35;
  localparam int XW = 38;
  localparam int ZW = 36;
  localparam int SQ_VW = 58;
  localparam int SQ_RW = 32;
  localparam int SQ_QW = 29;
  localparam int SQ_STEPS = 29;

  localparam logic signed [PW-1:0] ONE_Q28 = PW'(64'sd268435456);
  localparam logic signed [ZW-1:0] PI_Q30 = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0] PI_Q13 = ZW'(25736);
  localparam logic signed [ZW-1:0] HALF_PI_Q13 = ZW'(12868);

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cvec_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h3243F6A8;
      1: v = 32'h1DAC6705;
      2: v = 32'h0FADBAFC;
      3: v = 32'h07F56EA6;
      4: v = 32'h03FEAB76;
      5: v = 32'h01FFD55B;
      6: v = 32'h00FFFAAA;
      7: v = 32'h007FFF55;
      8: v = 32'h003FFFEA;
      9: v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return $signed({{(ZW-32){1'b0}}, v});
  endfunction

  // round q.30 to q.13 and saturate
  function automatic logic signed [15:0] round_sat(input logic signed [ZW-1:0] z,
                                                   input logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] t;
    logic signed [ZW-1:0] r;
    t = z + ZW'(65536);
    r = t >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/qte_cordic_cell.sv
`default_nettype none
module qte_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire qte_pkg::cvec_t  vin,
  output qte_pkg::cvec_t       vout
);

  logic signed [qte_pkg::XW-1:0] xs;
  logic signed [qte_pkg::XW-1:0] ys;

  assign xs = vin.x >>> STEP;
  assign ys = vin.y >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!vin.y[qte_pkg::XW-1]) begin
        vout.x <= vin.x + ys;
        vout.y <= vin.y - xs;
        vout.z <= vin.z + qte_pkg::atan_q30(STEP);
      end else begin
        vout.x <= vin.x - ys;
        vout.y <= vin.y + xs;
        vout.z <= vin.z - qte_pkg::atan_q30(STEP);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/qte_sqrt_cell.sv
`default_nettype none
module qte_sqrt_cell (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [qte_pkg::SQ_RW-1:0]   rem_in,
  input  wire logic [qte_pkg::SQ_QW-1:0]   root_in,
  input  wire logic [qte_pkg::SQ_VW-1:0]   val_in,
  output logic      [qte_pkg::SQ_RW-1:0]   rem_out,
  output logic      [qte_pkg::SQ_QW-1:0]   root_out,
  output logic      [qte_pkg::SQ_VW-1:0]   val_out
);

  logic [qte_pkg::SQ_RW-1:0] trial_rem;
  logic [qte_pkg::SQ_RW-1:0] trial_sub;

  assign trial_rem = {rem_in[qte_pkg::SQ_RW-3:0], val_in[qte_pkg::SQ_VW-1 -: 2]};
  assign trial_sub = qte_pkg::SQ_RW'({root_in, 2'b01});

  always_ff @(posedge clk) begin
    if (en) begin
      val_out <= val_in << 2;
      if (trial_rem >= trial_sub) begin
        rem_out  <= trial_rem - trial_sub;
        root_out <= {root_in[qte_pkg::SQ_QW-2:0], 1'b1};
      end else begin
        rem_out  <= trial_rem;
        root_out <= {root_in[qte_pkg::SQ_QW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/quaternion_to_euler_unit.sv
// quaternion to zyx euler angle converter
// input channel: quat_valid / quat_stall with quat_w, quat_x, quat_y, quat_z
// (signed q2.14). output channel: euler_valid / euler_stall with roll_angle,
// pitch_angle, yaw_angle (signed q3.13 radians, pitch_angle q2.13) and pitch_clamped.
// one word is taken per cycle while not stalled, and every word gives exactly one result word.
// from acceptance to euler_valid a word passes the products, the sums, the
// roll / yaw set-up with pitch squaring, the root chain input, the bit-pair
// square root chain for the pitch cosine, the pitch set-up, one cell per
// cordic iteration, and the output register. roll and yaw run through their
// own cordic cell rows and wait in a delay line to line up with pitch.
// throughput is one word per cycle; the pipeline is fully stalled while
// euler_valid is high and euler_stall is high, and quat_stall follows that.
// reset clears all valid flags; words in flight are dropped, no data is
// cleared.
`default_nettype none
module quaternion_to_euler_unit #(
  parameter int CORDIC_ITERATIONS = qte_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               quat_valid,
  output logic                    quat_stall,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  output logic                    euler_valid,
  input  wire logic               euler_stall,
  output logic signed [15:0]      roll_angle,
  output logic signed [14:0]      pitch_angle,
  output logic signed [15:0]      yaw_angle,
  output logic                    pitch_clamped
);

  localparam int N = CORDIC_ITERATIONS;
  localparam int LAT = 35 + N;
  localparam int RDLY = 30;
  localparam int SDLY = 30;
  localparam int CDLY = 31 + N;
  localparam int PW = qte_pkg::PW;
  localparam int XW = qte_pkg::XW;
  localparam int ZW = qte_pkg::ZW;

  logic en;
  logic [LAT-1:0] vld;

  assign en = !euler_valid || !euler_stall;
  assign quat_stall = !en;
  assign euler_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], quat_valid};
    end
  end

  // products
  logic signed [31:0] wx, yz, xx, yy, wy, zx, wz, xy, zz;
  always_ff @(posedge clk) begin
    if (en) begin
      wx <= quat_w * quat_x;
      yz <= quat_y * quat_z;
      xx <= quat_x * quat_x;
      yy <= quat_y * quat_y;
      wy <= quat_w * quat_y;
      zx <= quat_z * quat_x;
      wz <= quat_w * quat_z;
      xy <= quat_x * quat_y;
      zz <= quat_z * quat_z;
    end
  end

  // sums
  logic signed [PW-1:0] sinr, cosr, sinp, siny, cosy;
  always_ff @(posedge clk) begin
    if (en) begin
      sinr <= (PW'(wx) + PW'(yz)) <<< 1;
      cosr <= qte_pkg::ONE_Q28 - ((PW'(xx) + PW'(yy)) <<< 1);
      sinp <= (PW'(wy) - PW'(zx)) <<< 1;
      siny <= (PW'(wz) + PW'(xy)) <<< 1;
      cosy <= qte_pkg::ONE_Q28 - ((PW'(yy) + PW'(zz)) <<< 1);
    end
  end

  // roll / yaw set-up, pitch squaring
  qte_pkg::cvec_t cv_r [0:N];
  qte_pkg::cvec_t cv_y [0:N];
  qte_pkg::cvec_t cv_p [0:N];
  logic zr [0:CDLY];
  logic zy [0:CDLY];
  logic cl [0:CDLY];
  logic ps [0:CDLY];
  logic signed [28:0] sd [0:SDLY];
  logic [55:0] sq;
  logic [PW-1:0] sabs;

  assign sabs = sinp[PW-1] ? PW'(-sinp) : PW'(sinp);

  always_ff @(posedge clk) begin
    if (en) begin
      zr[0] <= (sinr == '0) && (cosr == '0);
      zy[0] <= (siny == '0) && (cosy == '0);
      if (cosr[PW-1]) begin
        cv_r[0].x <= -XW'(cosr);
        cv_r[0].y <= -XW'(sinr);
        cv_r[0].z <= sinr[PW-1] ? -qte_pkg::PI_Q30 : qte_pkg::PI_Q30;
      end else begin
        cv_r[0].x <= XW'(cosr);
        cv_r[0].y <= XW'(sinr);
        cv_r[0].z <= '0;
      end
      if (cosy[PW-1]) begin
        cv_y[0].x <= -XW'(cosy);
        cv_y[0].y <= -XW'(siny);
        cv_y[0].z <= siny[PW-1] ? -qte_pkg::PI_Q30 : qte_pkg::PI_Q30;
      end else begin
        cv_y[0].x <= XW'(cosy);
        cv_y[0].y <= XW'(siny);
        cv_y[0].z <= '0;
      end
      cl[0] <= (sinp >= qte_pkg::ONE_Q28) || (sinp <= -qte_pkg::ONE_Q28);
      ps[0] <= !sinp[PW-1];
      sd[0] <= sinp[28:0];
      sq <= sabs[27:0] * sabs[27:0];
      // side data delay lines
      for (int k = 0; k < CDLY; k++) begin
        zr[k+1] <= zr[k];
        zy[k+1] <= zy[k];
        cl[k+1] <= cl[k];
        ps[k+1] <= ps[k];
      end
      for (int k = 0; k < SDLY; k++) begin
        sd[k+1] <= sd[k];
      end
    end
  end

  // square root chain
  logic [qte_pkg::SQ_RW-1:0] sq_rem  [0:qte_pkg::SQ_STEPS];
  logic [qte_pkg::SQ_QW-1:0] sq_root [0:qte_pkg::SQ_STEPS];
  logic [qte_pkg::SQ_VW-1:0] sq_val  [0:qte_pkg::SQ_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_val[0]  <= (qte_pkg::SQ_VW'(1) << 56) - qte_pkg::SQ_VW'(sq);
    end
  end

  for (genvar k = 0; k < qte_pkg::SQ_STEPS; k++) begin : g_sqrt
    qte_sqrt_cell u_cell (
      .clk      (clk),
      .en       (en),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .val_in   (sq_val[k]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1]),
      .val_out  (sq_val[k+1])
    );
  end

  // pitch set-up
  always_ff @(posedge clk) begin
    if (en) begin
      cv_p[0].x <= XW'(sq_root[qte_pkg::SQ_STEPS]);
      cv_p[0].y <= XW'(sd[SDLY]);
      cv_p[0].z <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    qte_cordic_cell #(.STEP(i)) u_roll  (.clk(clk), .en(en), .vin(cv_r[i]), .vout(cv_r[i+1]));
    qte_cordic_cell #(.STEP(i)) u_yaw   (.clk(clk), .en(en), .vin(cv_y[i]), .vout(cv_y[i+1]));
    qte_cordic_cell #(.STEP(i)) u_pitch (.clk(clk), .en(en), .vin(cv_p[i]), .vout(cv_p[i+1]));
  end

  // roll / yaw angle wait line
  logic signed [ZW-1:0] rz [0:RDLY];
  logic signed [ZW-1:0] yz_d [0:RDLY];

  always_ff @(posedge clk) begin
    if (en) begin
      rz[0]   <= cv_r[N].z;
      yz_d[0] <= cv_y[N].z;
      for (int k = 0; k < RDLY; k++) begin
        rz[k+1]   <= rz[k];
        yz_d[k+1] <= yz_d[k];
      end
    end
  end

  logic signed [15:0] pitch_full;
  assign pitch_full = qte_pkg::round_sat(cv_p[N].z, qte_pkg::HALF_PI_Q13);

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle <= zr[CDLY] ? 16'sd0 : qte_pkg::round_sat(rz[RDLY], qte_pkg::PI_Q13);
      yaw_angle  <= zy[CDLY] ? 16'sd0 : qte_pkg::round_sat(yz_d[RDLY], qte_pkg::PI_Q13);
      if (cl[CDLY]) begin
        pitch_angle <= ps[CDLY] ? 15'sd12868 : -15'sd12868;
      end else begin
        pitch_angle <= pitch_full[14:0];
      end
      pitch_clamped <= cl[CDLY];
    end
  end

  a_clamp_pitch: assert property (@(posedge clk) disable iff (rst)
    euler_valid && pitch_clamped |-> pitch_angle == 15'sd12868 || pitch_angle == -15'sd12868)
    else $error("clamped pitch not at a right angle");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    euler_valid |-> roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736)
    else $error("roll out of range");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    euler_valid |-> yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736)
    else $error("yaw out of range");

  a_take: assert property (@(posedge clk) disable iff (rst)
    quat_valid && !quat_stall |=> vld[0])
    else $error("accepted word lost at entry");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    quat_stall |=> $stable(vld))
    else $error("pipeline moved while stalled");

endmodule
`default_nettype wire
